[hdl/kbs_pkg.sv]
// kbs_pkg: shared constants, register indexes and helper functions for the
// kinematic bicycle step unit; no dependencies
package kbs_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_IW          = 5;

    // fixed-point constants, angles in q.16 and q.30
    localparam logic [17:0] PI_Q16      = 18'd205888;
    localparam logic [18:0] TURN_Q16    = 19'd411776;
    localparam logic [17:0] HALF_PI_Q16 = 18'd102944;
    localparam logic [33:0] GAIN_Q30    = 34'd652032874;
    localparam logic [15:0] PEDAL_MAX   = 16'd32768;
    localparam logic [14:0] WB_MIN      = 15'd2048;

    // configuration register indexes
    localparam logic [2:0] REG_WHEELBASE = 3'd0;
    localparam logic [2:0] REG_MAX_ACCEL = 3'd1;
    localparam logic [2:0] REG_MAX_DECEL = 3'd2;
    localparam logic [2:0] REG_TIME_STEP = 3'd3;
    localparam logic [2:0] REG_GPS_PER   = 3'd4;
    localparam logic [2:0] REG_LIDAR_PER = 3'd5;

    function automatic logic [29:0] atan_q30(input logic [ATAN_IW-1:0] idx);
        logic [29:0] r;
        unique case (idx)
            5'd0:  r = 30'd843314856;
            5'd1:  r = 30'd497837829;
            5'd2:  r = 30'd263043836;
            5'd3:  r = 30'd133525158;
            5'd4:  r = 30'd67021686;
            5'd5:  r = 30'd33543515;
            5'd6:  r = 30'd16775850;
            5'd7:  r = 30'd8388437;
            5'd8:  r = 30'd4194282;
            5'd9:  r = 30'd2097149;
            5'd10: r = 30'd1048575;
            5'd11: r = 30'd524287;
            5'd12: r = 30'd262143;
            5'd13: r = 30'd131071;
            5'd14: r = 30'd65535;
            5'd15: r = 30'd32767;
            5'd16: r = 30'd16383;
            5'd17: r = 30'd8191;
            5'd18: r = 30'd4095;
            5'd19: r = 30'd2047;
            5'd20: r = 30'd1023;
            5'd21: r = 30'd511;
            5'd22: r = 30'd255;
            5'd23: r = 30'd127;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

    // q.30 to q.16, rounding half away from zero
    function automatic logic signed [17:0] rshr14(input logic signed [33:0] v);
        logic [33:0] m;
        logic [33:0] r;
        m = v[33] ? 34'(-v) : 34'(v);
        r = (m + 34'd8192) >> 14;
        return v[33] ? -$signed(r[17:0]) : $signed(r[17:0]);
    endfunction

endpackage

[hdl/kbs_if.sv]
// kbs_cmd_if and kbs_res_if: valid/ready channels of the step unit
// depends on nothing
interface kbs_cmd_if;
    logic               valid;
    logic               ready;
    logic [15:0]        throttle;
    logic [15:0]        brake;
    logic signed [14:0] steer;
    modport source (output valid, throttle, brake, steer, input ready);
    modport sink   (input valid, throttle, brake, steer, output ready);
endinterface

interface kbs_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [18:0] heading;
    logic [22:0]        speed;
    logic signed [23:0] turn_rate;
    logic               gps_due;
    logic               lidar_due;
    modport source (output valid, pos_x, pos_y, heading, speed, turn_rate, gps_due,
                    lidar_due, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, speed, turn_rate, gps_due,
                    lidar_due, output ready);
endinterface

[hdl/kbs_cordic.sv]
// kbs_cordic: iterative rotation-mode cordic, one micro-rotation per cycle
// depends on kbs_pkg
module kbs_cordic #(
    parameter int STEPS = kbs_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] z_in,
    output logic               done,
    output logic signed [17:0] s16,
    output logic signed [17:0] c16
);
    import kbs_pkg::*;

    localparam int IW = $clog2(STEPS);

    logic signed [33:0] x_reg, y_reg;
    logic signed [32:0] z_reg;
    logic [IW-1:0]      i_reg;
    logic               run_reg, done_reg;
    logic signed [33:0] dx, dy;
    logic signed [32:0] ang;

    always_comb
    begin
        dx  = y_reg >>> i_reg;
        dy  = x_reg >>> i_reg;
        ang = $signed({3'b000, atan_q30(ATAN_IW'(i_reg))});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (i_reg == IW'(STEPS - 1));
            if (start)
                run_reg <= 1'b1;
            else if (run_reg && (i_reg == IW'(STEPS - 1)))
                run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= $signed(GAIN_Q30);
            y_reg <= '0;
            z_reg <= 33'(z_in);
            i_reg <= '0;
        end
        else if (run_reg)
        begin
            if (!z_reg[32])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - ang;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + ang;
            end
            i_reg <= i_reg + 1'b1;
        end
    end

    assign done = done_reg;
    assign s16  = rshr14(y_reg);
    assign c16  = rshr14(x_reg);

endmodule

[hdl/kbs_div.sv]
// kbs_div: restoring divider, one quotient bit per cycle, 27 quotient bits
// depends on nothing; caller keeps dividend below divisor times 2^27
module kbs_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [52:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [26:0] quotient
);
    logic [32:0] rem_reg;
    logic [26:0] low_reg, q_reg;
    logic [31:0] div_reg;
    logic [4:0]  cnt_reg;
    logic        run_reg, done_reg;
    logic [32:0] trial;
    logic        fits;

    always_comb
    begin
        trial = {rem_reg[31:0], low_reg[26]};
        fits  = trial >= {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == 5'd26);
            if (start)
                run_reg <= 1'b1;
            else if (run_reg && (cnt_reg == 5'd26))
                run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {7'd0, dividend[52:27]};
            low_reg <= dividend[26:0];
            div_reg <= divisor;
            q_reg   <= '0;
            cnt_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? (trial - {1'b0, div_reg}) : trial;
            low_reg <= {low_reg[25:0], 1'b0};
            q_reg   <= {q_reg[25:0], fits};
            cnt_reg <= cnt_reg + 5'd1;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[hdl/kinematic_bicycle_step_unit.sv]
// kinematic_bicycle_step_unit: one euler step of a kinematic bicycle per item
// depends on kbs_pkg, kbs_if, kbs_cordic and kbs_div
//
// Each command item (throttle, brake, steer) advances speed, yaw rate, heading
// and position by one time step and returns one result item with the new
// state and the gps and lidar sample flags. The unit takes one item at a time
// and holds cmd.ready low while it works. An item passes through two cordic
// passes, the yaw rate divider, the heading wrap and the sequencer steps around
// the one shared 40x17 multiplier, the idle accept step and the result hand-off
// included. The finished result sits in an output register, so the next
// command is taken while the result waits; a result still waiting when the
// next one is done holds the sequencer in its last step. Configuration is
// written through cfg_we/cfg_index/cfg_data; the user must write it only while
// no item is in flight, which the block itself does not enforce.
module kinematic_bicycle_step_unit #(
    parameter int CORDIC_STEPS = kbs_pkg::CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    kbs_cmd_if.sink     cmd,
    kbs_res_if.source   res
);
    import kbs_pkg::*;

    // sequencer states
    localparam logic [4:0] S_IDLE = 5'd0,  S_ACC1 = 5'd1,  S_ACC2 = 5'd2,
                           S_ACC3 = 5'd3,  S_VDT  = 5'd4,  S_VEL  = 5'd5,
                           S_COR1 = 5'd6,  S_NUM  = 5'd7,  S_DEN  = 5'd8,
                           S_DIV  = 5'd9,  S_DIVW = 5'd10, S_HDT  = 5'd11,
                           S_HSUM = 5'd12, S_WRAP = 5'd13, S_HFIN = 5'd14,
                           S_COR2 = 5'd15, S_PX1  = 5'd16, S_PX2  = 5'd17,
                           S_PX3  = 5'd18, S_PY1  = 5'd19, S_PY2  = 5'd20,
                           S_PY3  = 5'd21, S_DONE = 5'd22;

    localparam logic [26:0] WRAP_BIAS = 27'(64 * 411776);

    // configuration registers
    logic [14:0] wb_reg;
    logic [15:0] maxa_reg, maxd_reg, dt_reg;
    logic [7:0]  gper_reg, lper_reg;

    // sequencer and datapath registers
    logic [4:0]         state_reg, state_next;
    logic [15:0]        thr_reg, brk_reg;
    logic signed [14:0] st_reg;
    logic [56:0]        mp_reg;
    logic [31:0]        acc_reg, amag_reg;
    logic               aneg_reg, nneg_reg, flip_reg;
    logic [39:0]        nmag_reg;
    logic signed [17:0] s_reg, c_reg;
    logic [25:0]        h_reg;
    logic [2:0]         k_reg;

    // model state
    logic [22:0]        vel_reg;
    logic signed [23:0] rate_reg;
    logic signed [18:0] head_reg;
    logic signed [31:0] px_reg, py_reg;
    logic [7:0]         gcnt_reg, lcnt_reg;

    // output register
    logic               ovalid_reg;
    logic signed [31:0] opx_reg, opy_reg;
    logic signed [18:0] ohead_reg;
    logic [22:0]        ovel_reg;
    logic signed [23:0] orate_reg;
    logic               ogps_reg, olid_reg;

    // shared multiplier operands
    logic [39:0] mul_a;
    logic [16:0] mul_b;

    // cordic and divider hookup
    logic               cor_start, cor_done;
    logic signed [31:0] cor_z;
    logic signed [17:0] cor_s, cor_c;
    logic               div_start, div_done;
    logic [52:0]        div_num;
    logic [26:0]        div_q;

    // combinational helpers
    logic               accept, out_load;
    logic [15:0]        thr_in, brk_in;
    logic signed [14:0] st_in;
    logic [14:0]        wb_eff;
    logic signed [32:0] acc_diff;
    logic [20:0]        dv;
    logic signed [24:0] vsum;
    logic [23:0]        rmag;
    logic [23:0]        dhm;
    logic signed [26:0] hsum;
    logic [25:0]        wrap_step;
    logic signed [18:0] hsc;
    logic [24:0]        dpos;
    logic signed [33:0] psum;
    logic signed [33:0] pbase;
    logic [8:0]         gsum, lsum;
    logic               gdue, ldue;

    assign accept   = cmd.valid && cmd.ready;
    assign out_load = (state_reg == S_DONE) && (!ovalid_reg || res.ready);
    assign cmd.ready = (state_reg == S_IDLE);

    // input clamps: pedals to one, steer to plus or minus one radian
    always_comb
    begin
        thr_in = (cmd.throttle > PEDAL_MAX) ? PEDAL_MAX : cmd.throttle;
        brk_in = (cmd.brake > PEDAL_MAX) ? PEDAL_MAX : cmd.brake;
        if (cmd.steer > 15'sd8192)
            st_in = 15'sd8192;
        else if (cmd.steer < -15'sd8192)
            st_in = -15'sd8192;
        else
            st_in = cmd.steer;
        wb_eff = (wb_reg < WB_MIN) ? WB_MIN : wb_reg;
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_ACC1: begin mul_a = 40'(thr_reg);  mul_b = 17'(maxa_reg); end
            S_ACC2: begin mul_a = 40'(brk_reg);  mul_b = 17'(maxd_reg); end
            S_VDT:  begin mul_a = 40'(amag_reg); mul_b = 17'(dt_reg);   end
            S_NUM:
            begin
                mul_a = 40'(vel_reg);
                mul_b = s_reg[17] ? 17'(-s_reg) : 17'(s_reg);
            end
            S_DEN:  begin mul_a = 40'(wb_eff); mul_b = 17'(c_reg); end
            S_HDT:
            begin
                // widen before negating so the most negative rate keeps its size
                mul_a = 40'(rate_reg[23] ? (25'sd0 - 25'(rate_reg)) : 25'(rate_reg));
                mul_b = 17'(dt_reg);
            end
            S_PX1:
            begin
                mul_a = 40'(vel_reg);
                mul_b = c_reg[17] ? 17'(-c_reg) : 17'(c_reg);
            end
            S_PY1:
            begin
                mul_a = 40'(vel_reg);
                mul_b = s_reg[17] ? 17'(-s_reg) : 17'(s_reg);
            end
            S_PX2, S_PY2: begin mul_a = mp_reg[39:0]; mul_b = 17'(dt_reg); end
            default: ;
        endcase
    end

    // datapath arithmetic
    always_comb
    begin
        acc_diff = $signed({1'b0, acc_reg}) - $signed({1'b0, mp_reg[31:0]});
        dv       = 21'((mp_reg[47:0] + 48'd67108864) >> 27);
        vsum     = aneg_reg ? ($signed({2'b00, vel_reg}) - $signed({4'b0000, dv}))
                            : ($signed({2'b00, vel_reg}) + $signed({4'b0000, dv}));
        rmag     = 24'((mp_reg[39:0] + 40'd32768) >> 16);
        dhm      = rmag;
        hsum     = 27'(head_reg) + (rate_reg[23] ? -$signed({3'b000, dhm})
                                                 : $signed({3'b000, dhm}))
                   + $signed({9'd0, PI_Q16}) + $signed(WRAP_BIAS);
        wrap_step = 26'({7'd0, TURN_Q16} << k_reg);
        hsc      = 19'($signed({1'b0, h_reg}) - $signed({9'd0, PI_Q16}));
        dpos     = 25'((mp_reg[55:0] + 56'd2147483648) >> 32);
        pbase    = (state_reg == S_PX3) ? 34'(px_reg) : 34'(py_reg);
        if (((state_reg == S_PX3) && c_reg[17]) || ((state_reg == S_PY3) && s_reg[17]))
            psum = pbase - $signed({9'd0, dpos});
        else
            psum = pbase + $signed({9'd0, dpos});
        gsum = {1'b0, gcnt_reg} + 9'd1;
        lsum = {1'b0, lcnt_reg} + 9'd1;
        gdue = gsum >= {1'b0, gper_reg};
        ldue = lsum >= {1'b0, lper_reg};
    end

    // cordic start: steer angle after speed update, heading after wrap
    always_comb
    begin
        cor_start = (state_reg == S_VEL) || (state_reg == S_HFIN);
        if (hsc > $signed({1'b0, HALF_PI_Q16}))
            cor_z = {18'(hsc - $signed({1'b0, PI_Q16})), 14'd0};
        else if (hsc < -$signed({1'b0, HALF_PI_Q16}))
            cor_z = {18'(hsc + $signed({1'b0, PI_Q16})), 14'd0};
        else
            cor_z = {hsc[17:0], 14'd0};
        if (state_reg == S_VEL)
            cor_z = {st_reg, 17'd0};
        div_start = (state_reg == S_DIV);
        div_num   = {1'b0, nmag_reg, 12'd0} + 53'(mp_reg[31:1]);
    end

    kbs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .z_in  (cor_z),
        .done  (cor_done),
        .s16   (cor_s),
        .c16   (cor_c)
    );

    kbs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (mp_reg[31:0]),
        .done     (div_done),
        .quotient (div_q)
    );

    // next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_ACC1;
            S_ACC1: state_next = S_ACC2;
            S_ACC2: state_next = S_ACC3;
            S_ACC3: state_next = S_VDT;
            S_VDT:  state_next = S_VEL;
            S_VEL:  state_next = S_COR1;
            S_COR1: if (cor_done) state_next = S_NUM;
            S_NUM:  state_next = S_DEN;
            S_DEN:  state_next = S_DIV;
            S_DIV:  state_next = S_DIVW;
            S_DIVW: if (div_done) state_next = S_HDT;
            S_HDT:  state_next = S_HSUM;
            S_HSUM: state_next = S_WRAP;
            S_WRAP: if (k_reg == 3'd0) state_next = S_HFIN;
            S_HFIN: state_next = S_COR2;
            S_COR2: if (cor_done) state_next = S_PX1;
            S_PX1:  state_next = S_PX2;
            S_PX2:  state_next = S_PX3;
            S_PX3:  state_next = S_PY1;
            S_PY1:  state_next = S_PY2;
            S_PY2:  state_next = S_PY3;
            S_PY3:  state_next = S_DONE;
            S_DONE: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control state, model state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            wb_reg     <= 15'd11059;
            maxa_reg   <= 16'd8192;
            maxd_reg   <= 16'd16384;
            dt_reg     <= 16'd1311;
            gper_reg   <= 8'd25;
            lper_reg   <= 8'd5;
            vel_reg    <= '0;
            head_reg   <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            gcnt_reg   <= '0;
            lcnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WHEELBASE: wb_reg   <= cfg_data[14:0];
                    REG_MAX_ACCEL: maxa_reg <= cfg_data;
                    REG_MAX_DECEL: maxd_reg <= cfg_data;
                    REG_TIME_STEP: dt_reg   <= cfg_data;
                    REG_GPS_PER:   gper_reg <= cfg_data[7:0];
                    REG_LIDAR_PER: lper_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            // speed clamps at zero and saturates at the field maximum
            if (state_reg == S_VEL)
            begin
                if (vsum < 0)
                    vel_reg <= '0;
                else if (vsum > 25'sd8388607)
                    vel_reg <= 23'h7FFFFF;
                else
                    vel_reg <= vsum[22:0];
            end
            if (state_reg == S_HFIN)
                head_reg <= hsc;
            if (state_reg == S_PX3)
            begin
                if (psum > 34'sd2147483647)
                    px_reg <= 32'sh7FFFFFFF;
                else if (psum < -34'sd2147483648)
                    px_reg <= 32'sh80000000;
                else
                    px_reg <= psum[31:0];
            end
            if (state_reg == S_PY3)
            begin
                if (psum > 34'sd2147483647)
                    py_reg <= 32'sh7FFFFFFF;
                else if (psum < -34'sd2147483648)
                    py_reg <= 32'sh80000000;
                else
                    py_reg <= psum[31:0];
            end
            // tick counters; a period of zero flags every tick
            if (out_load)
            begin
                gcnt_reg <= gdue ? 8'd0 : gsum[7:0];
                lcnt_reg <= ldue ? 8'd0 : lsum[7:0];
            end
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (res.ready)
                ovalid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mp_reg <= 57'(mul_a) * 57'(mul_b);
        if (accept)
        begin
            thr_reg <= thr_in;
            brk_reg <= brk_in;
            st_reg  <= st_in;
        end
        if (state_reg == S_ACC2)
            acc_reg <= mp_reg[31:0];
        if (state_reg == S_ACC3)
        begin
            aneg_reg <= acc_diff[32];
            amag_reg <= acc_diff[32] ? 32'(-acc_diff) : 32'(acc_diff);
        end
        if ((state_reg == S_COR1) && cor_done)
        begin
            s_reg <= cor_s;
            c_reg <= cor_c;
        end
        if (state_reg == S_DEN)
        begin
            nmag_reg <= mp_reg[39:0];
            nneg_reg <= s_reg[17];
        end
        // yaw rate saturates to the field range
        if ((state_reg == S_DIVW) && div_done)
        begin
            if (nneg_reg)
                rate_reg <= (div_q > 27'd8388608) ? -24'sd8388608
                                                  : -$signed(24'(div_q));
            else
                rate_reg <= (div_q > 27'd8388607) ? 24'sd8388607
                                                  : $signed(24'(div_q));
        end
        // heading wrap: bias positive, then strip multiples of a turn
        if (state_reg == S_HSUM)
        begin
            h_reg <= hsum[25:0];
            k_reg <= 3'd6;
        end
        if (state_reg == S_WRAP)
        begin
            if (h_reg >= wrap_step)
                h_reg <= h_reg - wrap_step;
            k_reg <= k_reg - 3'd1;
        end
        if (state_reg == S_HFIN)
            flip_reg <= (hsc > $signed({1'b0, HALF_PI_Q16}))
                        || (hsc < -$signed({1'b0, HALF_PI_Q16}));
        if ((state_reg == S_COR2) && cor_done)
        begin
            s_reg <= flip_reg ? -cor_s : cor_s;
            c_reg <= flip_reg ? -cor_c : cor_c;
        end
        if (out_load)
        begin
            opx_reg   <= px_reg;
            opy_reg   <= py_reg;
            ohead_reg <= head_reg;
            ovel_reg  <= vel_reg;
            orate_reg <= rate_reg;
            ogps_reg  <= gdue;
            olid_reg  <= ldue;
        end
    end

    assign res.valid     = ovalid_reg;
    assign res.pos_x     = opx_reg;
    assign res.pos_y     = opy_reg;
    assign res.heading   = ohead_reg;
    assign res.speed     = ovel_reg;
    assign res.turn_rate = orate_reg;
    assign res.gps_due   = ogps_reg;
    assign res.lidar_due = olid_reg;

    // an accepted command starts the sequence on the next cycle
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_ACC1))
        else $error("accepted item did not start the sequencer");

    // cordic finishes only while the sequencer waits for it
    a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
        cor_done |-> (state_reg == S_COR1 || state_reg == S_COR2))
        else $error("cordic finished outside a wait state");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVW))
        else $error("divider finished outside its wait state");

    // wrapped heading stays in [-pi, pi)
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.heading >= -19'sd205888 && res.heading <= 19'sd205887))
        else $error("heading outside wrap range");

endmodule
